// ----- sv/pmi_pkg.sv -----
// Shared constants and helpers for the planar motion integrator.
// No dependencies.
package pmi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PROD_SHIFT = 16;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int HW = 22;

   localparam logic signed [HW-1:0] ANG_TWO_PI   = 22'sd411775;
   localparam logic signed [HW-1:0] ANG_PI       = 22'sd205887;
   localparam logic signed [HW-1:0] ANG_HALF_PI  = 22'sd102944;
   localparam logic signed [HW-1:0] ANG_3HALF_PI = 22'sd308831;

   localparam logic signed [19:0] COEF_1 = 20'sd65497;
   localparam logic signed [19:0] COEF_2 = -20'sd32478;
   localparam logic signed [19:0] COEF_3 = 20'sd2411;

   localparam logic [3:0] REG_SPEED_LIMIT  = 4'd0;
   localparam logic [3:0] REG_ACCEL_LIMIT  = 4'd1;
   localparam logic [3:0] REG_SPIN_LIMIT   = 4'd2;
   localparam logic [3:0] REG_TURN_LIMIT   = 4'd3;
   localparam logic [3:0] REG_LINEAR_ACCEL = 4'd4;
   localparam logic [3:0] REG_TURN_RATE    = 4'd5;
   localparam logic [3:0] REG_SPIN_ACCEL   = 4'd6;
   localparam logic [3:0] REG_DAMPING      = 4'd7;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -40'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   function automatic logic signed [31:0] min32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ----- sv/pmi_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on pmi_pkg.
module pmi_mul
   import pmi_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] prod_ff
);

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/pmi_isqrt.sv -----
// Bit-pair iterative integer square root, one result bit per cycle.
// Depends on nothing.
module pmi_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] value,
   output logic        done_ff,
   output logic [16:0] root
);

   logic        busy_ff;
   logic [32:0] v_ff;
   logic [33:0] res_ff;
   logic [32:0] bit_ff;
   logic [33:0] trial;

   assign trial = res_ff + {1'b0, bit_ff};
   assign root  = res_ff[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            v_ff    <= value;
            res_ff  <= '0;
            bit_ff  <= 33'h1_0000_0000;
         end else if (busy_ff) begin
            if ({1'b0, v_ff} >= trial) begin
               v_ff   <= v_ff - trial[32:0];
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ----- sv/planar_motion_integrator.sv -----
// Planar motion integrator: sequencer, state and control registers.
// An advance item passes through the integrate states, the heading wrap state (repeated
// until the heading is in range), the trig states, the square root wait and a finish.
// A load item goes straight to the finish state. The next item is taken in the cycle
// after the result is registered; a stalled result holds the block. One item at a time.
// Synchronous reset clears the motion state to zero and the registers to their defaults.
module planar_motion_integrator
   import pmi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [15:0]        req_dt,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_speed,
   input  logic [18:0]        req_load_heading,
   input  logic signed [31:0] req_load_body_angle,
   input  logic signed [31:0] req_load_spin,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic [18:0]        rsp_out_heading,
   output logic signed [31:0] rsp_out_body_angle,
   output logic signed [31:0] rsp_out_speed,
   output logic signed [31:0] rsp_out_spin,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CAP, ST_SPIN, ST_SPEED, ST_HEAD, ST_DAMP, ST_BODY, ST_MOVE,
      ST_WRAP, ST_TRIG, ST_R2, ST_POLY, ST_COS, ST_REM, ST_X, ST_SQRT, ST_Y, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] speed_limit_ff, accel_limit_ff, spin_limit_ff;
   logic signed [19:0] turn_limit_ff, turn_rate_ff;
   logic signed [31:0] linear_accel_ff, spin_accel_ff;
   logic [15:0]        damping_ff;

   logic signed [31:0] x_ff, y_ff, speed_ff, body_ff, spin_ff;
   logic [18:0]        heading_ff;

   logic [15:0]           dt_ff;
   logic signed [HW-1:0]  h_ff;
   logic signed [31:0]    mv_ff;
   logic [17:0]           r2_ff;
   logic signed [18:0]    cs_ff;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [37:0]        p_sh;

   logic                sq_start, sq_done;
   logic [32:0]         sq_value;
   logic [16:0]         sq_root;

   logic signed [HW-1:0] r_full;
   logic                 cos_neg, sin_neg;
   logic signed [17:0]   t_val;
   logic signed [18:0]   cvp, cv;
   logic signed [34:0]   rem;
   logic signed [18:0]   sn;
   logic                 req_take;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign p_sh      = prod[MUL_P_W-1:PROD_SHIFT];

   assign cos_neg = (h_ff >= ANG_HALF_PI) && (h_ff < ANG_3HALF_PI);
   assign sin_neg = (h_ff >= ANG_PI);

   always_comb begin
      if (h_ff < ANG_HALF_PI)       r_full = h_ff;
      else if (h_ff < ANG_PI)       r_full = ANG_PI - h_ff;
      else if (h_ff < ANG_3HALF_PI) r_full = h_ff - ANG_PI;
      else                          r_full = ANG_TWO_PI - h_ff;
   end

   assign t_val = p_sh[17:0] + COEF_2[17:0];
   assign cvp   = p_sh[18:0] + COEF_1[18:0];
   assign cv    = cos_neg ? -cvp : cvp;
   assign rem   = (35'sd1 <<< 32) - prod[34:0];
   assign sq_value = (rem > 35'sd0) ? rem[32:0] : 33'd0;
   assign sq_start = (state_ff == ST_REM);
   assign sn    = sin_neg ? -$signed({2'b00, sq_root}) : $signed({2'b00, sq_root});

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_CAP: begin
            op_a = MUL_A_W'(spin_accel_ff);
            op_b = MUL_B_W'({1'b0, dt_ff});
         end
         ST_SPIN: begin
            op_a = MUL_A_W'(linear_accel_ff);
            op_b = MUL_B_W'({1'b0, dt_ff});
         end
         ST_SPEED: begin
            op_a = MUL_A_W'(turn_rate_ff);
            op_b = MUL_B_W'({1'b0, dt_ff});
         end
         ST_HEAD: begin
            op_a = MUL_A_W'(speed_ff);
            op_b = MUL_B_W'({1'b0, 17'h10000 - {1'b0, damping_ff}});
         end
         ST_DAMP: begin
            op_a = MUL_A_W'(spin_ff);
            op_b = MUL_B_W'({1'b0, dt_ff});
         end
         ST_BODY: begin
            op_a = MUL_A_W'(speed_ff);
            op_b = MUL_B_W'({1'b0, dt_ff});
         end
         ST_TRIG: begin
            op_a = MUL_A_W'(r_full);
            op_b = r_full[MUL_B_W-1:0];
         end
         ST_R2: begin
            op_a = MUL_A_W'(COEF_3);
            op_b = MUL_B_W'({1'b0, p_sh[17:0]});
         end
         ST_POLY: begin
            op_a = MUL_A_W'({1'b0, r2_ff});
            op_b = MUL_B_W'(t_val);
         end
         ST_COS: begin
            op_a = MUL_A_W'(cv);
            op_b = MUL_B_W'(cv);
         end
         ST_REM: begin
            op_a = MUL_A_W'(mv_ff);
            op_b = MUL_B_W'(cs_ff);
         end
         ST_SQRT: begin
            op_a = MUL_A_W'(mv_ff);
            op_b = MUL_B_W'(sn);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = (req_command == CMD_LOAD) ? ST_FIN : ST_CAP;
         ST_CAP:   state_in = ST_SPIN;
         ST_SPIN:  state_in = ST_SPEED;
         ST_SPEED: state_in = ST_HEAD;
         ST_HEAD:  state_in = ST_DAMP;
         ST_DAMP:  state_in = ST_BODY;
         ST_BODY:  state_in = ST_MOVE;
         ST_MOVE:  state_in = ST_WRAP;
         ST_WRAP:  if (h_ff >= 0 && h_ff <= ANG_TWO_PI) state_in = ST_TRIG;
         ST_TRIG:  state_in = ST_R2;
         ST_R2:    state_in = ST_POLY;
         ST_POLY:  state_in = ST_COS;
         ST_COS:   state_in = ST_REM;
         ST_REM:   state_in = ST_X;
         ST_X:     state_in = ST_SQRT;
         ST_SQRT:  if (sq_done) state_in = ST_Y;
         ST_Y:     state_in = ST_FIN;
         ST_FIN:   if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid       <= 1'b0;
         speed_limit_ff  <= 32'sh7FFFFFFF;
         accel_limit_ff  <= 32'sh7FFFFFFF;
         spin_limit_ff   <= 32'sh7FFFFFFF;
         turn_limit_ff   <= 20'sd411774;
         linear_accel_ff <= '0;
         turn_rate_ff    <= '0;
         spin_accel_ff   <= '0;
         damping_ff      <= '0;
         x_ff            <= '0;
         y_ff            <= '0;
         speed_ff        <= '0;
         heading_ff      <= '0;
         body_ff         <= '0;
         spin_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && !rsp_stall && state_ff != ST_FIN) rsp_valid <= 1'b0;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata;
               REG_ACCEL_LIMIT:  accel_limit_ff  <= csr_wdata;
               REG_SPIN_LIMIT:   spin_limit_ff   <= csr_wdata;
               REG_TURN_LIMIT:   turn_limit_ff   <= csr_wdata[19:0];
               REG_LINEAR_ACCEL: linear_accel_ff <= csr_wdata;
               REG_TURN_RATE:    turn_rate_ff    <= csr_wdata[19:0];
               REG_SPIN_ACCEL:   spin_accel_ff   <= csr_wdata;
               REG_DAMPING:      damping_ff      <= csr_wdata[15:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  dt_ff  <= req_dt;
                  if (req_command == CMD_LOAD) begin
                     x_ff       <= req_load_x;
                     y_ff       <= req_load_y;
                     speed_ff   <= req_load_speed;
                     heading_ff <= req_load_heading;
                     body_ff    <= req_load_body_angle;
                     spin_ff    <= req_load_spin;
                  end
               end
            end
            ST_CAP: begin
               if (turn_limit_ff < turn_rate_ff) turn_rate_ff <= turn_limit_ff;
               linear_accel_ff <= min32(accel_limit_ff, linear_accel_ff);
            end
            ST_SPIN: spin_ff <= min32(spin_limit_ff,
                                      sat32(40'(spin_ff) + 40'(p_sh)));
            ST_SPEED: speed_ff <= sat32(40'(speed_ff) + 40'(p_sh));
            ST_HEAD: h_ff <= $signed({3'b000, heading_ff}) + p_sh[HW-1:0];
            ST_DAMP: speed_ff <= min32(speed_limit_ff, p_sh[31:0]);
            ST_BODY: body_ff <= body_ff + p_sh[31:0];
            ST_MOVE: mv_ff <= p_sh[31:0];
            ST_WRAP: begin
               if (h_ff < 0) h_ff <= h_ff + ANG_TWO_PI;
               else if (h_ff > ANG_TWO_PI) h_ff <= h_ff - ANG_TWO_PI;
               else heading_ff <= h_ff[18:0];
            end
            ST_R2: r2_ff <= p_sh[17:0];
            ST_COS: cs_ff <= cv;
            ST_X: x_ff <= sat32(40'(x_ff) + 40'(p_sh));
            ST_Y: y_ff <= sat32(40'(y_ff) + 40'(p_sh));
            ST_FIN: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid          <= 1'b1;
                  rsp_out_x          <= x_ff;
                  rsp_out_y          <= y_ff;
                  rsp_out_heading    <= heading_ff;
                  rsp_out_body_angle <= body_ff;
                  rsp_out_speed      <= speed_ff;
                  rsp_out_spin       <= spin_ff;
               end
            end
            default: ;
         endcase
      end
   end

   pmi_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   pmi_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .value   (sq_value),
      .done_ff (sq_done),
      .root    (sq_root)
   );

endmodule

// ----- verif/tb_planar_motion_integrator.sv -----
// Self-checking testbench for planar_motion_integrator: a directed table, then
// random items under several register settings and idling mixes, each result
// checked against an in-bench step predictor. Depends on pmi_pkg and the RTL.
module tb_planar_motion_integrator
   import pmi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] REG_FIRST_UNUSED = 4'd8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 79;

   typedef struct {
      logic signed [31:0] x, y;
      logic [18:0]        heading;
      logic signed [31:0] body, speed, spin;
   } motion_type;

   typedef struct {
      logic               cmd;
      logic [15:0]        dt;
      logic signed [31:0] x, y, speed;
      logic [18:0]        heading;
      logic signed [31:0] body, spin;
      bit                 known;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_ADVANCE;
   logic [15:0] req_dt = '0;
   logic signed [31:0] req_load_x = '0, req_load_y = '0, req_load_speed = '0;
   logic [18:0] req_load_heading = '0;
   logic signed [31:0] req_load_body_angle = '0, req_load_spin = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_body_angle, rsp_out_speed, rsp_out_spin;
   logic [18:0] rsp_out_heading;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   planar_motion_integrator dut (.*);

   always #5 clock = ~clock;

   // predictor copy of registers and motion state
   longint lim_speed, lim_accel, lim_spin, lim_turn, lin_accel, turn_rt, spin_acc, damp;
   longint pos_x, pos_y, cur_speed, cur_spin, cur_heading;
   int unsigned cur_body;

   motion_type expected_motion[$];
   step_type directed[$];
   int errors = 0;
   int send_idle_pct = 0, stall_pct = 0;
   int quiet_cycles = 0;
   bit run_done = 0;

   function automatic longint sat32_l(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint min_l(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint cos_poly(longint r);
      longint r2, t;
      r2 = (r * r) >>> FRAC_BITS;
      t = longint'(COEF_2) + ((longint'(COEF_3) * r2) >>> FRAC_BITS);
      return longint'(COEF_1) + ((r2 * t) >>> FRAC_BITS);
   endfunction

   function automatic motion_type state_now();
      motion_type m;
      m.x = pos_x[31:0];
      m.y = pos_y[31:0];
      m.heading = cur_heading[18:0];
      m.body = cur_body;
      m.speed = cur_speed[31:0];
      m.spin = cur_spin[31:0];
      return m;
   endfunction

   task automatic reset_model();
      lim_speed = 2147483647; lim_accel = 2147483647; lim_spin = 2147483647;
      lim_turn = 411774; lin_accel = 0; turn_rt = 0; spin_acc = 0; damp = 0;
      pos_x = 0; pos_y = 0; cur_speed = 0; cur_spin = 0; cur_heading = 0; cur_body = 0;
   endtask

   task automatic model_config(logic [3:0] idx, logic [31:0] d);
      case (idx)
         REG_SPEED_LIMIT:  lim_speed = longint'($signed(d));
         REG_ACCEL_LIMIT:  lim_accel = longint'($signed(d));
         REG_SPIN_LIMIT:   lim_spin = longint'($signed(d));
         REG_TURN_LIMIT:   lim_turn = longint'($signed(d[19:0]));
         REG_LINEAR_ACCEL: lin_accel = longint'($signed(d));
         REG_TURN_RATE:    turn_rt = longint'($signed(d[19:0]));
         REG_SPIN_ACCEL:   spin_acc = longint'($signed(d));
         REG_DAMPING:      damp = longint'(d[15:0]);
         default: ;
      endcase
   endtask

   function automatic motion_type integrate_step(step_type s);
      longint dtl, h, cv, sn, mv, rem;
      if (s.cmd == CMD_LOAD) begin
         pos_x = s.x; pos_y = s.y; cur_speed = s.speed;
         cur_heading = s.heading; cur_body = s.body; cur_spin = s.spin;
         return state_now();
      end
      dtl = s.dt;
      turn_rt = min_l(lim_turn, turn_rt);
      lin_accel = min_l(lim_accel, lin_accel);
      cur_spin = min_l(lim_spin, sat32_l(cur_spin + ((spin_acc * dtl) >>> 16)));
      cur_speed = sat32_l(cur_speed + ((lin_accel * dtl) >>> 16));
      cur_speed = (cur_speed * (65536 - damp)) >>> 16;
      cur_speed = min_l(lim_speed, cur_speed);
      h = cur_heading + ((turn_rt * dtl) >>> 16);
      while (h < 0) h += longint'(ANG_TWO_PI);
      while (h > longint'(ANG_TWO_PI)) h -= longint'(ANG_TWO_PI);
      cur_heading = h & 64'h7FFFF;
      cur_body = cur_body + 32'((cur_spin * dtl) >>> 16);
      if (h < longint'(ANG_HALF_PI)) cv = cos_poly(h);
      else if (h < longint'(ANG_PI)) cv = -cos_poly(longint'(ANG_PI) - h);
      else if (h < longint'(ANG_3HALF_PI)) cv = -cos_poly(h - longint'(ANG_PI));
      else cv = cos_poly(longint'(ANG_TWO_PI) - h);
      rem = (64'sd1 << (2 * FRAC_BITS)) - cv * cv;
      sn = rem > 0 ? longint'(int_sqrt(rem)) : 0;
      if (h >= longint'(ANG_PI)) sn = -sn;
      mv = (cur_speed * dtl) >>> 16;
      pos_x = sat32_l(pos_x + ((mv * cv) >>> FRAC_BITS));
      pos_y = sat32_l(pos_y + ((mv * sn) >>> FRAC_BITS));
      return state_now();
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      motion_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_motion.size() == 0) begin
            report("unexpected item", 0, 0);
         end else begin
            e = expected_motion.pop_front();
            if (rsp_out_x !== e.x) report("x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report("y", rsp_out_y, e.y);
            if (rsp_out_heading !== e.heading) report("heading", rsp_out_heading, e.heading);
            if (rsp_out_body_angle !== e.body) report("body", rsp_out_body_angle, e.body);
            if (rsp_out_speed !== e.speed) report("speed", rsp_out_speed, e.speed);
            if (rsp_out_spin !== e.spin) report("spin", rsp_out_spin, e.spin);
         end
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready) || run_done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d items outstanding", expected_motion.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_step(step_type s);
      motion_type m;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= s.cmd;
      req_dt <= s.dt;
      req_load_x <= s.x;
      req_load_y <= s.y;
      req_load_speed <= s.speed;
      req_load_heading <= s.heading;
      req_load_body_angle <= s.body;
      req_load_spin <= s.spin;
      do @(posedge clock); while (req_stall);
      m = integrate_step(s);
      if (s.known) begin
         m.x = s.x; m.y = s.y; m.heading = s.heading;
         m.body = s.body; m.speed = s.speed; m.spin = s.spin;
      end
      expected_motion.push_back(m);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      model_config(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic step_type row(logic cmd, logic [15:0] dt, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [31:0] sp,
                                    logic [18:0] hd, logic signed [31:0] ba,
                                    logic signed [31:0] sn, bit known);
      step_type s;
      s.cmd = cmd; s.dt = dt; s.x = x; s.y = y; s.speed = sp;
      s.heading = hd; s.body = ba; s.spin = sn; s.known = known;
      return s;
   endfunction

   function automatic logic [31:0] pick32(int sel, logic [31:0] small_span);
      case (sel)
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, small_span * 2) - small_span;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_turn(int sel);
      case (sel)
         0: return 32'd411774;
         1: return -32'sd411774;
         2: return $urandom_range(0, 823548) - 411774;
         default: return $urandom();
      endcase
   endfunction

   function automatic step_type random_step();
      step_type s;
      bit wide;
      s.known = 0;
      s.cmd = ($urandom_range(99) < 18) ? CMD_LOAD : CMD_ADVANCE;
      s.dt = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 2047)) : 16'($urandom());
      wide = ($urandom_range(3) == 0);
      s.x = wide ? $urandom() : $urandom_range(0, 1 << 24) - (1 << 23);
      s.y = wide ? $urandom() : $urandom_range(0, 1 << 24) - (1 << 23);
      s.speed = wide ? $urandom() : $urandom_range(0, 1 << 23) - (1 << 22);
      s.heading = ($urandom_range(9) == 0) ? 19'($urandom()) : 19'($urandom_range(0, 411775));
      s.body = $urandom();
      s.spin = wide ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
      return s;
   endfunction

   initial begin
      int sel;
      reset_model();
      directed.push_back(row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1));
      directed.push_back(row(CMD_LOAD, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             19'd411775, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
      directed.push_back(row(CMD_ADVANCE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             19'd411775, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                             19'd0, 32'h80000000, 32'h80000000, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 0, 0, 32'sd65536, 19'h7FFFF, -1, 32'sd65536, 1));
      directed.push_back(row(CMD_ADVANCE, 16'd1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 0, 0, 32'sd65536, ANG_HALF_PI[18:0], 0, 0, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 0, 0, 32'sd65536, ANG_PI[18:0], 0, 0, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 0, 0, -32'sd65536, ANG_3HALF_PI[18:0], 0, 0, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 0, 0, 0, 32'sd200000, 19'd300000, 0, 0, 1));
      directed.push_back(row(CMD_ADVANCE, 16'h8000, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(CMD_LOAD, 16'h0000, 32'h7FFFFF00, 32'h80000100, 32'h7FFFFFFF,
                             19'd51472, 32'hFFFFFFF0, 32'h7FFFFFFF, 1));
      directed.push_back(row(CMD_ADVANCE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_step(directed[i]);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         for (int r = 0; r <= 7; r++) begin
            sel = (ph < 2) ? ph : $urandom_range(0, 3);
            case (4'(r))
               REG_TURN_LIMIT, REG_TURN_RATE: write_reg(4'(r), pick_turn(sel));
               REG_DAMPING: write_reg(4'(r), (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF :
                                      (sel == 2) ? $urandom_range(0, 4000) : $urandom());
               REG_LINEAR_ACCEL, REG_SPIN_ACCEL: write_reg(4'(r), pick32(sel, 1 << 22));
               default: write_reg(4'(r), pick32(sel, 1 << 26));
            endcase
         end
         write_reg(REG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom());
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 80; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 80; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (expected_motion.size() != 0) @(posedge clock);
               @(negedge clock);
            end
            send_step(random_step());
         end
         stall_pct = 0;
         drain();
      end

      run_done = 1;
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
